// File: rtl/core/fwcrc_pkg.sv
package fwcrc_pkg;

    // CRC-32, reflected form.
    localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
    localparam logic [31:0] CRC_ONES  = 32'hFFFFFFFF;
    localparam logic [31:0] SIG_RESET = 32'h55AA5A5A;

    // Header layout: eight big-endian words, the CRC covers the first 28 bytes.
    localparam int HDR_CRC_BYTES = 28;
    localparam int HDR_BYTES     = 32;
    localparam int HDR_WORDS     = 8;
    localparam int WIDX_W        = $clog2(HDR_WORDS);
    localparam int CNT_W         = 33;

    localparam int QUEUE_DEPTH = 4;

    // Result packing: status, then header words 1 to 6, padded to whole bytes.
    localparam int NUM_FIELDS = 6;
    localparam int RES_W      = 2 + 32 * NUM_FIELDS;
    localparam int OUT_W      = ((RES_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        KIND_HDR_CRC,   // header byte that also enters the header CRC
        KIND_HDR_TAIL,  // header byte past the CRC span
        KIND_PAYLOAD,   // payload byte, enters the image CRC
        KIND_TRAILER    // byte past the payload, ignored
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_BAD_HEADER   = 2'd1,
        ST_TOO_SHORT    = 2'd2,
        ST_CRC_MISMATCH = 2'd3
    } status_t;

    // One classified byte as it travels from the front end to the back end.
    typedef struct packed {
        logic [7:0]        data;
        kind_t             kind;
        logic              hcrc_end;
        logic [WIDX_W-1:0] widx;
        logic              last;
        logic              incomplete;
        logic              too_short;
    } entry_t;

    typedef struct packed {
        logic [NUM_FIELDS-1:0][31:0] fields;
        status_t                     status;
    } result_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

// File: rtl/core/fwcrc_front.sv
module fwcrc_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [7:0]        s_data,
    input  logic              s_last,
    input  logic              accept,
    output fwcrc_pkg::entry_t entry
);
    import fwcrc_pkg::*;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0]      len_reg, len_next;

    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] pay_off;
    logic [CNT_W-1:0] need_total;
    logic             is_hdr;
    logic             in_payload;
    logic             len_byte;

    always_comb begin
        cnt_inc    = (&cnt_reg) ? cnt_reg : cnt_reg + CNT_W'(1);
        is_hdr     = cnt_reg < CNT_W'(HDR_BYTES);
        pay_off    = cnt_reg - CNT_W'(HDR_BYTES);
        in_payload = pay_off < {1'b0, len_reg};
        need_total = CNT_W'(HDR_BYTES) + {1'b0, len_reg};
        // Bytes 16 to 19 carry the payload length word.
        len_byte   = is_hdr && (cnt_reg[4:2] == WIDX_W'(4));

        entry.data       = s_data;
        entry.widx       = cnt_reg[4:2];
        entry.last       = s_last;
        entry.hcrc_end   = cnt_reg == CNT_W'(HDR_CRC_BYTES - 1);
        entry.incomplete = cnt_inc < CNT_W'(HDR_BYTES);
        entry.too_short  = cnt_inc < need_total;

        priority if (cnt_reg < CNT_W'(HDR_CRC_BYTES)) begin
            entry.kind = KIND_HDR_CRC;
        end else if (is_hdr) begin
            entry.kind = KIND_HDR_TAIL;
        end else if (in_payload) begin
            entry.kind = KIND_PAYLOAD;
        end else begin
            entry.kind = KIND_TRAILER;
        end

        cnt_next = cnt_reg;
        len_next = len_reg;
        if (accept) begin
            if (s_last) begin
                cnt_next = '0;
                len_next = '0;
            end else begin
                cnt_next = cnt_inc;
                if (len_byte) begin
                    len_next = {len_reg[23:0], s_data};
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            len_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            len_reg <= len_next;
        end
    end

endmodule

// File: rtl/core/fwcrc_queue.sv
module fwcrc_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  fwcrc_pkg::entry_t push_entry,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output fwcrc_pkg::entry_t head_entry
);
    import fwcrc_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    entry_t           mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg, count_next;

    always_comb begin
        full       = count_reg == (PTR_W + 1)'(QUEUE_DEPTH);
        head_valid = count_reg != '0;
        head_entry = mem_reg[rd_ptr_reg];
        count_next = count_reg + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

// File: rtl/core/fwcrc_back.sv
module fwcrc_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           head_valid,
    input  fwcrc_pkg::entry_t              head_entry,
    output logic                           pop,
    input  logic [31:0]                    signature,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [fwcrc_pkg::OUT_W-1:0]    m_tdata
);
    import fwcrc_pkg::*;

    logic [31:0] words_reg  [HDR_WORDS];
    logic [31:0] words_next [HDR_WORDS];
    logic [31:0] crc_reg, crc_next;
    logic [31:0] hcrc_reg, hcrc_next;
    logic [31:0] crc_upd;
    logic        out_valid_reg;
    result_t     out_data_reg;
    result_t     res;
    logic        is_hdr;

    always_comb begin
        // A last byte may leave only if the output register is empty or draining.
        pop     = head_valid && (!head_entry.last || !out_valid_reg || m_tready);
        is_hdr  = (head_entry.kind == KIND_HDR_CRC) || (head_entry.kind == KIND_HDR_TAIL);
        crc_upd = crc_byte(crc_reg, head_entry.data);

        for (int k = 0; k < HDR_WORDS; k++) begin
            words_next[k] = words_reg[k];
        end
        if (is_hdr) begin
            words_next[head_entry.widx] = {words_reg[head_entry.widx][23:0], head_entry.data};
        end

        crc_next  = crc_reg;
        hcrc_next = hcrc_reg;
        unique case (head_entry.kind)
            KIND_HDR_CRC: begin
                if (head_entry.hcrc_end) begin
                    hcrc_next = crc_upd ^ CRC_ONES;
                    crc_next  = CRC_ONES;
                end else begin
                    crc_next = crc_upd;
                end
            end
            KIND_PAYLOAD:  crc_next = crc_upd;
            KIND_HDR_TAIL: crc_next = crc_reg;
            KIND_TRAILER:  crc_next = crc_reg;
            default:       crc_next = crc_reg;
        endcase

        priority if (head_entry.incomplete) begin
            res.status = ST_BAD_HEADER;
        end else if (words_next[0] != signature || words_next[7] != hcrc_next) begin
            res.status = ST_BAD_HEADER;
        end else if (head_entry.too_short) begin
            res.status = ST_TOO_SHORT;
        end else if ((crc_next ^ CRC_ONES) != words_next[5]) begin
            res.status = ST_CRC_MISMATCH;
        end else begin
            res.status = ST_OK;
        end
        for (int k = 0; k < NUM_FIELDS; k++) begin
            res.fields[k] = head_entry.incomplete ? 32'd0 : words_next[k + 1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            crc_reg       <= CRC_ONES;
            hcrc_reg      <= '0;
            for (int k = 0; k < HDR_WORDS; k++) begin
                words_reg[k] <= '0;
            end
        end else begin
            // A new result may replace one that leaves in the same cycle.
            if (pop && head_entry.last) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (pop) begin
                if (head_entry.last) begin
                    crc_reg  <= CRC_ONES;
                    hcrc_reg <= '0;
                    for (int k = 0; k < HDR_WORDS; k++) begin
                        words_reg[k] <= '0;
                    end
                end else begin
                    crc_reg  <= crc_next;
                    hcrc_reg <= hcrc_next;
                    for (int k = 0; k < HDR_WORDS; k++) begin
                        words_reg[k] <= words_next[k];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && head_entry.last) begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_W - RES_W)'(0), out_data_reg};

endmodule

// File: rtl/core/firmware_image_crc_validator.sv
// Firmware image header and payload CRC checker.
//
// The image arrives on the s_ stream channel one byte per transfer, header
// first, with s_tlast set on the final byte. The first 32 bytes form a header
// of eight big-endian words. Word 0 must equal the signature register and
// word 7 must equal the CRC-32 of bytes 0 to 27. The CRC-32 then runs over the
// payload length given in word 4, and bytes beyond that are ignored.
// For each image one result transfer leaves on the m_ channel, holding the
// status (0 ok, 1 bad or incomplete header, 2 image too short, 3 payload CRC
// mismatch) and header words 1 to 6.
//
// The block takes one byte per cycle. A front end classifies each byte by its
// position and feeds a four-entry queue; the back end does one CRC byte update
// per cycle. With the queue empty, the last byte passes through the queue and
// then the output register before m_tvalid rises. If the receiver stalls, the
// result waits in the output register, the next last byte waits at the head of
// the queue, and s_tready falls once the queue is full. The cfg_ channel writes
// the expected signature (reset value 0x55AA5A5A). It is always ready and
// should be written only while no image is in flight. Reset empties the queue
// and the output register and clears all per-image state.
module firmware_image_crc_validator (
    input  logic                        aclk,
    input  logic                        aresetn,
    // Byte input. s_tdata: data_byte in bits 7:0. s_tlast: last_byte.
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,
    input  logic                        s_tlast,
    // Result. m_tdata from bit 0: status (2), hardware_id (32),
    // hardware_timestamp (32), image_version (32), payload_length (32),
    // stored_image_crc (32), watchdog_timeout (32), zero padding (6).
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [fwcrc_pkg::OUT_W-1:0] m_tdata,
    // Signature register write.
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [31:0]                 cfg_data
);
    import fwcrc_pkg::*;

    logic        sig_write;
    logic [31:0] signature_reg;
    logic        accept;
    logic        q_full;
    logic        head_valid;
    logic        pop;
    entry_t      front_entry;
    entry_t      head_entry;

    // The byte is accepted whenever the queue has room.
    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign sig_write = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            signature_reg <= SIG_RESET;
        end else if (sig_write) begin
            signature_reg <= cfg_data;
        end
    end

    // The front end tracks the byte position and the payload length on its own,
    // so it can tag each byte without waiting on the back end.
    fwcrc_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_tdata),
        .s_last  (s_tlast),
        .accept  (accept),
        .entry   (front_entry)
    );

    fwcrc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (accept),
        .push_entry (front_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    // The back end holds the header words and the running CRC, and builds the
    // result when the tagged last byte comes out of the queue.
    fwcrc_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .signature  (signature_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

// File: rtl/core/fwcrc_checker.sv
module fwcrc_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [fwcrc_pkg::OUT_W-1:0] m_tdata
);
    import fwcrc_pkg::*;

    // Reset empties the output register.
    a_reset_clears_out: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A stalled result holds its value.
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // The padding above the result fields stays zero.
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[OUT_W-1:RES_W] == '0)
        else $error("nonzero padding in result");

    // The queue can only fill up from an input transfer.
    a_full_after_push: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_tready) |-> $past(s_tvalid))
        else $error("input backpressure without an input transfer");

endmodule

bind firmware_image_crc_validator fwcrc_checker u_fwcrc_checker (.*);
